// File: rtl/core/tcw_pkg.sv
// Shared types, codes and microcode tables of the text console writer.
package tcw_pkg;

   localparam logic [2:0] KIND_PUT_CURSOR = 3'd0;
   localparam logic [2:0] KIND_PUT_AT     = 3'd1;
   localparam logic [2:0] KIND_BACKSPACE  = 3'd2;
   localparam logic [2:0] KIND_CLEAR      = 3'd3;
   localparam logic [2:0] KIND_READ       = 3'd4;

   localparam logic CSR_TEXT_ATTR  = 1'b0;
   localparam logic CSR_ERROR_ATTR = 1'b1;

   localparam logic [7:0] NEWLINE_CODE     = 8'h0A;
   localparam logic [7:0] ERROR_MARK       = 8'h45;
   localparam logic [7:0] SPACE_CODE       = 8'h20;
   localparam logic [7:0] DEFAULT_ATTR     = 8'h0F;
   localparam logic [7:0] TEXT_ATTR_RESET  = 8'h0F;
   localparam logic [7:0] ERROR_ATTR_RESET = 8'hF4;

   typedef enum logic [3:0] {
      S_RST,
      S_RST_FILL,
      S_RST_DONE,
      S_PUTP,
      S_PUT,
      S_SCROLL_RD,
      S_SCROLL_WR,
      S_FILL,
      S_RESPOND,
      S_IDLE,
      S_ERRMARK,
      S_BKSP,
      S_CLEAR,
      S_READP,
      S_READ_MEM
   } step_type;

   typedef enum logic [3:0] {
      A_NOP,
      A_INIT_ZERO,
      A_FILL,
      A_POS_INPUT,
      A_PUT,
      A_SCROLL_RD,
      A_SCROLL_WR,
      A_RESPOND,
      A_ACCEPT,
      A_ERRMARK,
      A_BKSP,
      A_INIT_CLEAR,
      A_READ
   } act_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_SWEEP_MORE,
      C_SCROLL_MORE,
      C_BAD,
      C_NO_WRAP,
      C_RSP_BUSY,
      C_DISPATCH
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ctrl_type;

   // Control store: a taken condition jumps to target, otherwise the step counter advances.
   function automatic ctrl_type ucode_rom(input step_type step);
      ctrl_type word;
      unique case (step)
         S_RST:       word = '{act: A_INIT_ZERO,  cond: C_NONE,        target: S_RST};
         S_RST_FILL:  word = '{act: A_FILL,       cond: C_SWEEP_MORE,  target: S_RST_FILL};
         S_RST_DONE:  word = '{act: A_NOP,        cond: C_ALWAYS,      target: S_IDLE};
         S_PUTP:      word = '{act: A_POS_INPUT,  cond: C_BAD,         target: S_ERRMARK};
         S_PUT:       word = '{act: A_PUT,        cond: C_NO_WRAP,     target: S_RESPOND};
         S_SCROLL_RD: word = '{act: A_SCROLL_RD,  cond: C_NONE,        target: S_SCROLL_RD};
         S_SCROLL_WR: word = '{act: A_SCROLL_WR,  cond: C_SCROLL_MORE, target: S_SCROLL_RD};
         S_FILL:      word = '{act: A_FILL,       cond: C_SWEEP_MORE,  target: S_FILL};
         S_RESPOND:   word = '{act: A_RESPOND,    cond: C_RSP_BUSY,    target: S_RESPOND};
         S_IDLE:      word = '{act: A_ACCEPT,     cond: C_DISPATCH,    target: S_IDLE};
         S_ERRMARK:   word = '{act: A_ERRMARK,    cond: C_ALWAYS,      target: S_RESPOND};
         S_BKSP:      word = '{act: A_BKSP,       cond: C_ALWAYS,      target: S_RESPOND};
         S_CLEAR:     word = '{act: A_INIT_CLEAR, cond: C_ALWAYS,      target: S_FILL};
         S_READP:     word = '{act: A_POS_INPUT,  cond: C_BAD,         target: S_RESPOND};
         S_READ_MEM:  word = '{act: A_READ,       cond: C_ALWAYS,      target: S_RESPOND};
         default:     word = '{act: A_NOP,        cond: C_ALWAYS,      target: S_RST};
      endcase
      return word;
   endfunction

   // Entry point of each command kind; unused kinds just report the cursor.
   function automatic step_type dispatch_rom(input logic [2:0] kind);
      step_type entry;
      unique case (kind)
         KIND_PUT_CURSOR: entry = S_PUT;
         KIND_PUT_AT:     entry = S_PUTP;
         KIND_BACKSPACE:  entry = S_BKSP;
         KIND_CLEAR:      entry = S_CLEAR;
         KIND_READ:       entry = S_READP;
         default:         entry = S_RESPOND;
      endcase
      return entry;
   endfunction

endpackage

// File: rtl/core/text_console_writer.sv
// Text console writer: command stream in, one status beat out per command.
//
// Each req beat is one command (put at cursor, put at position, backspace,
// clear, read cell); each command returns exactly one rsp beat with the
// cursor position after the command, the position error flag and, for a
// read, the cell bytes. Configuration writes on the csr port set the text
// and error attributes and are taken in any cycle.
// A small microcode store sequences a cell memory with one write port and one
// registered read port (one write and one registered read per cycle).
// Each command runs its own steps before the respond step loads the result.
// A put at position or a read first decodes the position; a bad one writes
// the error mark (put) or skips the cell read (read). A put that runs past
// the last row scrolls: each row below the first is copied one row up and
// the last row is zero filled. Clear refills every cell. A command is taken
// in the idle step after the previous result has been loaded into the output
// register, so a new command is never taken while the previous one still runs.
// After reset a clearing pass zeroes the cell memory with req_tready low.
// A result waits in the output register while rsp_tready is low; the next
// command is still accepted and runs up to its own result.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // character, column, row
   input  logic [2:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_position, position_error, read_character,
                                    // read_attribute, zero fill
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   logic [15:0] cell_mem [CELLS];

   step_type step_ff, step_in;
   ctrl_type ctrl;
   logic     take;

   logic [7:0] text_attr_ff, text_attr_in;
   logic [7:0] error_attr_ff, error_attr_in;

   logic [2:0] kind_ff, kind_in;
   logic [7:0] char_ff, char_in;
   logic [7:0] in_col_ff, in_col_in;
   logic [7:0] in_row_ff, in_row_in;

   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] pcol_ff, pcol_in;
   logic [RW-1:0] prow_ff, prow_in;

   logic [AW-1:0] cursor_ff, cursor_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;

   logic [AW-1:0] addr_ff, addr_in;
   logic [15:0]   fill_ff, fill_in;
   logic [15:0]   rd_data_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [10:0] rsp_cursor_ff, rsp_cursor_in;
   logic        rsp_err_ff, rsp_err_in;
   logic [7:0]  rsp_rch_ff, rsp_rch_in;
   logic [7:0]  rsp_rattr_ff, rsp_rattr_in;

   logic       req_accept;
   logic       rsp_busy;
   logic       bad;
   logic [7:0] eff_attr;
   logic       is_nl;
   logic       adv_row;
   logic       wrap;
   logic       is_read;

   assign ctrl       = ucode_rom(step_ff);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_busy   = rsp_tvalid_ff && !rsp_tready;
   assign bad        = ({1'b0, in_col_ff} >= 9'(COLUMNS)) || ({1'b0, in_row_ff} >= 9'(ROWS));
   assign eff_attr   = (text_attr_ff != 8'd0) ? text_attr_ff : DEFAULT_ATTR;
   assign is_nl      = (char_ff == NEWLINE_CODE);
   assign adv_row    = is_nl || (pcol_ff == CW'(COLUMNS - 1));
   assign wrap       = adv_row && (prow_ff == RW'(ROWS - 1));
   assign is_read    = (kind_ff == KIND_READ) && !bad;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_rattr_ff, rsp_rch_ff, rsp_err_ff, rsp_cursor_ff};

   // Sequencer: next step.
   always_comb begin
      take = 1'b0;
      unique case (ctrl.cond)
         C_NONE:        take = 1'b0;
         C_ALWAYS:      take = 1'b1;
         C_SWEEP_MORE:  take = (addr_ff != AW'(CELLS - 1));
         C_SCROLL_MORE: take = (addr_ff != AW'(CELLS - COLUMNS - 1));
         C_BAD:         take = bad;
         C_NO_WRAP:     take = !wrap;
         C_RSP_BUSY:    take = rsp_busy;
         C_DISPATCH:    take = 1'b0;
         default:       take = 1'b0;
      endcase
      if (take) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(4'(step_ff) + 4'd1);
      end
      if (ctrl.cond == C_DISPATCH) begin
         step_in = req_accept ? dispatch_rom(req_tuser) : step_ff;
      end
   end

   // Configuration registers.
   always_comb begin
      text_attr_in  = text_attr_ff;
      error_attr_in = error_attr_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TEXT_ATTR:  text_attr_in  = csr_wdata;
            CSR_ERROR_ATTR: error_attr_in = csr_wdata;
            default:        text_attr_in  = text_attr_ff;
         endcase
      end
   end

   // Datapath controls decoded from the current control word.
   always_comb begin
      req_tready    = 1'b0;
      kind_in       = kind_ff;
      char_in       = char_ff;
      in_col_in     = in_col_ff;
      in_row_in     = in_row_ff;
      pos_in        = pos_ff;
      pcol_in       = pcol_ff;
      prow_in       = prow_ff;
      cursor_in     = cursor_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      addr_in       = addr_ff;
      fill_in       = fill_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = fill_ff;
      rd_en         = 1'b0;
      rd_addr       = pos_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_cursor_in = rsp_cursor_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_rch_in    = rsp_rch_ff;
      rsp_rattr_in  = rsp_rattr_ff;

      unique case (ctrl.act)
         A_NOP: begin
         end
         A_INIT_ZERO: begin
            addr_in = '0;
            fill_in = '0;
         end
         A_FILL: begin
            wr_en   = 1'b1;
            addr_in = addr_ff + AW'(1);
         end
         A_POS_INPUT: begin
            pos_in  = AW'(32'(in_row_ff) * COLUMNS + 32'(in_col_ff));
            pcol_in = CW'(in_col_ff);
            prow_in = RW'(in_row_ff);
         end
         A_PUT: begin
            wr_en   = !is_nl;
            wr_addr = pos_ff;
            wr_data = {eff_attr, char_ff};
            // A scroll that may follow starts its sweep at the first cell.
            addr_in = '0;
            fill_in = '0;
            if (wrap) begin
               cursor_in  = AW'(CELLS - COLUMNS);
               cur_col_in = '0;
               cur_row_in = RW'(ROWS - 1);
            end else if (adv_row) begin
               cursor_in  = pos_ff - AW'(pcol_ff) + AW'(COLUMNS);
               cur_col_in = '0;
               cur_row_in = prow_ff + RW'(1);
            end else begin
               cursor_in  = pos_ff + AW'(1);
               cur_col_in = pcol_ff + CW'(1);
               cur_row_in = prow_ff;
            end
         end
         A_SCROLL_RD: begin
            rd_en   = 1'b1;
            rd_addr = AW'(32'(addr_ff) + COLUMNS);
         end
         A_SCROLL_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            addr_in = addr_ff + AW'(1);
         end
         A_RESPOND: begin
            if (!rsp_busy) begin
               rsp_tvalid_in = 1'b1;
               rsp_cursor_in = 11'(cursor_ff);
               rsp_err_in    = bad && ((kind_ff == KIND_PUT_AT) || (kind_ff == KIND_READ));
               rsp_rch_in    = is_read ? rd_data_ff[7:0] : 8'd0;
               rsp_rattr_in  = is_read ? rd_data_ff[15:8] : 8'd0;
            end
         end
         A_ACCEPT: begin
            req_tready = 1'b1;
            if (req_accept) begin
               kind_in   = req_tuser;
               char_in   = req_tdata[7:0];
               in_col_in = req_tdata[15:8];
               in_row_in = req_tdata[23:16];
               pos_in    = cursor_ff;
               pcol_in   = cur_col_ff;
               prow_in   = cur_row_ff;
            end
         end
         A_ERRMARK: begin
            wr_en   = 1'b1;
            wr_addr = AW'(CELLS - 2);
            wr_data = {error_attr_ff, ERROR_MARK};
         end
         A_BKSP: begin
            if (cursor_ff != '0) begin
               wr_en     = 1'b1;
               wr_addr   = cursor_ff - AW'(1);
               wr_data   = {eff_attr, 8'd0};
               cursor_in = cursor_ff - AW'(1);
               if (cur_col_ff == '0) begin
                  cur_col_in = CW'(COLUMNS - 1);
                  cur_row_in = cur_row_ff - RW'(1);
               end else begin
                  cur_col_in = cur_col_ff - CW'(1);
               end
            end
         end
         A_INIT_CLEAR: begin
            addr_in    = '0;
            fill_in    = {eff_attr, SPACE_CODE};
            cursor_in  = '0;
            cur_col_in = '0;
            cur_row_in = '0;
         end
         A_READ: begin
            rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= S_RST;
         text_attr_ff  <= TEXT_ATTR_RESET;
         error_attr_ff <= ERROR_ATTR_RESET;
         cursor_ff     <= '0;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         text_attr_ff  <= text_attr_in;
         error_attr_ff <= error_attr_in;
         cursor_ff     <= cursor_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      char_ff       <= char_in;
      in_col_ff     <= in_col_in;
      in_row_ff     <= in_row_in;
      pos_ff        <= pos_in;
      pcol_ff       <= pcol_in;
      prow_ff       <= prow_in;
      addr_ff       <= addr_in;
      fill_ff       <= fill_in;
      rsp_cursor_ff <= rsp_cursor_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_rch_ff    <= rsp_rch_in;
      rsp_rattr_ff  <= rsp_rattr_in;
   end

`ifndef NO_ASSERTIONS
   // The cursor index and its column and row copies must always agree.
   a_cursor_map: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) == 32'(cur_row_ff) * COLUMNS + 32'(cur_col_ff))
      else $error("cursor index does not match its column and row");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_col_ff) < COLUMNS) && (32'(cur_row_ff) < ROWS))
      else $error("cursor column or row out of range");

   // Sweeps over the cell memory never address past the last cell.
   a_sweep_range: assert property (@(posedge clock) disable iff (reset)
      ((step_ff == S_FILL) || (step_ff == S_RST_FILL) || (step_ff == S_SCROLL_WR))
      |-> (32'(addr_ff) < CELLS))
      else $error("sweep address beyond the cell memory");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the text console writer: directed table, then random phases.
module tb_top;
   import tcw_pkg::*;

   localparam int COLUMNS         = 80;
   localparam int ROWS            = 25;
   localparam int CELLS           = COLUMNS * ROWS;
   localparam int LIMIT_CYCLES    = 8_000_000;
   localparam int DIRECTED_ROWS   = 23;
   localparam int RANDOM_PHASES   = 5;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int PRESSURE_AT     = 150;
   localparam int PRESSURE_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 50;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [2:0] KIND_SPARE_A = 3'd5;
   localparam logic [2:0] KIND_SPARE_B = 3'd6;
   localparam logic [2:0] KIND_SPARE_C = 3'd7;
   localparam logic [7:0] CHAR_A       = 8'h41;

   // Same bit order as rsp_tdata[27:0]: cursor in the lowest bits.
   typedef struct packed {
      logic [7:0]  rattr;
      logic [7:0]  rch;
      logic        err;
      logic [10:0] cursor;
   } status_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] ch;
      logic [7:0] col;
      logic [7:0] row;
      logic       typed;
      status_type want;
   } cmd_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // character, column, row
   logic [2:0]  req_tuser;   // kind
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // cursor_position, position_error, read_character,
                             // read_attribute, zero fill
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   // Predicted console state.
   logic [15:0] screen_cells [CELLS];
   int          cursor_model;
   logic [7:0]  text_attr_model;
   logic [7:0]  error_attr_model;

   status_type  expected_status [$];
   cmd_row_type directed_table [DIRECTED_ROWS];
   int          failures;
   int          commands_sent;
   int          status_seen;
   int          scroll_count;
   int          clear_count;
   int          send_burst;
   longint      cycle_count;

   text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic status_type status_word(input int cursor, input int err,
                                              input logic [7:0] rch, input logic [7:0] rattr);
      status_type s;
      s.cursor = cursor[10:0];
      s.err    = err[0];
      s.rch    = rch;
      s.rattr  = rattr;
      return s;
   endfunction

   function automatic logic [7:0] glyph_attr();
      return (text_attr_model != 8'h00) ? text_attr_model : DEFAULT_ATTR;
   endfunction

   function automatic void place_char(input int pos, input logic [7:0] ch);
      int next;
      if (ch == NEWLINE_CODE) begin
         next = (pos / COLUMNS + 1) * COLUMNS;
      end else begin
         screen_cells[pos] = {glyph_attr(), ch};
         next = pos + 1;
      end
      if (next >= CELLS) begin
         for (int i = 0; i + COLUMNS < CELLS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++) screen_cells[i] = 16'h0000;
         next -= COLUMNS;
         scroll_count++;
      end
      cursor_model = next;
   endfunction

   // Applies one command to the predicted state and returns the status beat it must produce.
   function automatic status_type console_step(input logic [2:0] kind, input logic [7:0] ch,
                                               input logic [7:0] col, input logic [7:0] row);
      status_type s;
      logic       bad;
      int         pos;
      s   = '0;
      bad = (col >= COLUMNS) || (row >= ROWS);
      pos = row * COLUMNS + col;
      case (kind)
         KIND_PUT_CURSOR: begin
            if (cursor_model >= CELLS) cursor_model = 0;
            place_char(cursor_model, ch);
         end
         KIND_PUT_AT: begin
            if (bad) begin
               screen_cells[CELLS - 2] = {error_attr_model, ERROR_MARK};
               s.err = 1'b1;
            end else begin
               place_char(pos, ch);
            end
         end
         KIND_BACKSPACE: begin
            if (cursor_model > 0 && cursor_model <= CELLS) begin
               cursor_model--;
               screen_cells[cursor_model] = {glyph_attr(), 8'h00};
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELLS; i++) screen_cells[i] = {glyph_attr(), SPACE_CODE};
            cursor_model = 0;
            clear_count++;
         end
         KIND_READ: begin
            if (bad) s.err = 1'b1;
            else {s.rattr, s.rch} = screen_cells[pos];
         end
         default: ;
      endcase
      s.cursor = cursor_model[10:0];
      return s;
   endfunction

   task automatic sender_gap();
      int gap;
      int r;
      gap = 0;
      if (send_burst > 0) begin
         send_burst--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 50)      gap = 0;
         else if (r < 85) gap = $urandom_range(1, 3);
         else if (r < 95) gap = $urandom_range(4, 10);
         else             gap = $urandom_range(20, 60);
         if ($urandom_range(0, 31) == 0) send_burst = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Offers one command beat and records its expected status once it is taken.
   task automatic send_cmd(input logic [2:0] kind, input logic [7:0] ch, input logic [7:0] col,
                           input logic [7:0] row, input logic typed, input status_type want);
      status_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {row, col, ch};
      do @(posedge clock); while (!req_tready);
      predicted = console_step(kind, ch, col, row);
      expected_status.push_back(typed ? want : predicted);
      commands_sent++;
      sender_gap();
   endtask

   task automatic random_cmd();
      int         r;
      int         spot;
      logic [2:0] kind;
      logic [7:0] ch;
      logic [7:0] col;
      logic [7:0] row;
      r = $urandom_range(0, 99);
      if (r < 45)      kind = KIND_PUT_CURSOR;
      else if (r < 65) kind = KIND_PUT_AT;
      else if (r < 73) kind = KIND_BACKSPACE;
      else if (r < 75) kind = KIND_CLEAR;
      else if (r < 93) kind = KIND_READ;
      else             kind = 3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C));
      ch = ($urandom_range(0, 7) == 0) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 15) begin
         col = 8'($urandom_range(0, 255));
         row = 8'($urandom_range(0, 255));
      end else if (kind == KIND_READ && r < 60 && cursor_model > 0) begin
         // Read back the cell just written so that reads see real content.
         spot = cursor_model - 1;
         col  = 8'(spot % COLUMNS);
         row  = 8'(spot / COLUMNS);
      end else begin
         col = 8'($urandom_range(0, COLUMNS - 1));
         row = 8'($urandom_range(0, ROWS - 1));
      end
      send_cmd(kind, ch, col, row, 1'b0, '0);
   endtask

   task automatic drain_status();
      req_tvalid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_attributes(input logic [7:0] text_attr, input logic [7:0] error_attr);
      csr_we    <= 1'b1;
      csr_index <= CSR_TEXT_ATTR;
      csr_wdata <= text_attr;
      @(posedge clock);
      csr_index <= CSR_ERROR_ATTR;
      csr_wdata <= error_attr;
      @(posedge clock);
      csr_we <= 1'b0;
      text_attr_model  = text_attr;
      error_attr_model = error_attr;
   endtask

   task automatic check_status(input logic [31:0] beat);
      status_type got;
      status_type want;
      got = beat[27:0];
      status_seen++;
      if (expected_status.size() == 0) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("Unexpected status beat %h at cycle %0d", beat, cycle_count);
      end else begin
         want = expected_status.pop_front();
         if (got.cursor !== want.cursor || got.err !== want.err || got.rch !== want.rch ||
             got.rattr !== want.rattr || beat[31:28] !== 4'h0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("Beat %0d: cursor %0d/%0d error %0b/%0b char %h/%h attr %h/%h fill %h",
                        status_seen, want.cursor, got.cursor, want.err, got.err,
                        want.rch, got.rch, want.rattr, got.rattr, beat[31:28]);
         end
      end
   endtask

   // Receiver: random stalls, bursts without stalls, and one long hold-off to back up the block.
   initial begin
      int stall_left;
      int burst_left;
      int r;
      bit pressured;
      stall_left = 0;
      burst_left = 0;
      pressured  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready) check_status(rsp_tdata);
         if (!pressured && status_seen >= PRESSURE_AT) begin
            pressured  = 1'b1;
            stall_left = PRESSURE_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_tready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(9, 39);
            end
            if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(20, 80);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) @(posedge clock) cycle_count++;
      $display("Timeout after %0d cycles, %0d status beats outstanding",
               cycle_count, expected_status.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [7:0]  text_set  [RANDOM_PHASES];
      logic [7:0]  error_set [RANDOM_PHASES];
      cmd_row_type step_row;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_we     = 1'b0;
      csr_index  = CSR_TEXT_ATTR;
      csr_wdata  = '0;
      failures      = 0;
      commands_sent = 0;
      status_seen   = 0;
      scroll_count  = 0;
      clear_count   = 0;
      send_burst    = 0;
      for (int i = 0; i < CELLS; i++) screen_cells[i] = 16'h0000;
      cursor_model     = 0;
      text_attr_model  = TEXT_ATTR_RESET;
      error_attr_model = ERROR_ATTR_RESET;

      directed_table = '{
         '{KIND_READ,       8'h00,        8'd0,   8'd0,   1'b1, status_word(0, 0, 8'h00, 8'h00)},
         '{KIND_READ,       8'h00,        8'd79,  8'd24,  1'b1, status_word(0, 0, 8'h00, 8'h00)},
         '{KIND_PUT_AT,     CHAR_A,       8'd80,  8'd0,   1'b1, status_word(0, 1, 8'h00, 8'h00)},
         '{KIND_READ,       8'h00,        8'd78,  8'd24,  1'b1,
           status_word(0, 0, ERROR_MARK, ERROR_ATTR_RESET)},
         '{KIND_READ,       8'h00,        8'd255, 8'd255, 1'b1, status_word(0, 1, 8'h00, 8'h00)},
         '{KIND_PUT_AT,     CHAR_A,       8'd0,   8'd25,  1'b1, status_word(0, 1, 8'h00, 8'h00)},
         '{KIND_BACKSPACE,  8'h00,        8'd0,   8'd0,   1'b1, status_word(0, 0, 8'h00, 8'h00)},
         '{KIND_PUT_CURSOR, 8'hFF,        8'd0,   8'd0,   1'b0, '0},
         '{KIND_PUT_CURSOR, 8'h00,        8'd255, 8'd255, 1'b0, '0},
         '{KIND_PUT_CURSOR, NEWLINE_CODE, 8'd0,   8'd0,   1'b0, '0},
         '{KIND_PUT_AT,     8'h7F,        8'd79,  8'd0,   1'b0, '0},
         '{KIND_READ,       8'h00,        8'd79,  8'd0,   1'b0, '0},
         '{KIND_BACKSPACE,  8'hFF,        8'd0,   8'd0,   1'b0, '0},
         '{KIND_READ,       8'h00,        8'd79,  8'd0,   1'b0, '0},
         '{KIND_PUT_AT,     NEWLINE_CODE, 8'd5,   8'd24,  1'b0, '0},
         '{KIND_PUT_AT,     8'h55,        8'd79,  8'd24,  1'b0, '0},
         '{KIND_READ,       8'h00,        8'd0,   8'd23,  1'b0, '0},
         '{KIND_SPARE_A,    8'hFF,        8'd255, 8'd255, 1'b0, '0},
         '{KIND_SPARE_B,    8'h00,        8'd0,   8'd0,   1'b0, '0},
         '{KIND_SPARE_C,    8'hAA,        8'd100, 8'd30,  1'b0, '0},
         '{KIND_CLEAR,      8'h00,        8'd0,   8'd0,   1'b1, status_word(0, 0, 8'h00, 8'h00)},
         '{KIND_READ,       8'h00,        8'd40,  8'd12,  1'b1,
           status_word(0, 0, SPACE_CODE, DEFAULT_ATTR)},
         '{KIND_PUT_AT,     8'hAA,        8'd255, 8'd0,   1'b0, '0}
      };

      text_set  = '{8'h00, 8'hFF, 8'($urandom_range(1, 254)), 8'h01, 8'($urandom_range(0, 255))};
      error_set = '{8'hFF, 8'h00, 8'($urandom_range(1, 254)), 8'($urandom_range(0, 255)), 8'h80};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The directed rows run with the reset attributes.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         step_row = directed_table[i];
         send_cmd(step_row.kind, step_row.ch, step_row.col, step_row.row, step_row.typed,
                  step_row.want);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_status();
         set_attributes(text_set[phase], error_set[phase]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) random_cmd();
      end

      drain_status();
      if (expected_status.size() != 0) failures += expected_status.size();

      $display("Ran %0d commands over %0d attribute settings in %0d cycles",
               commands_sent, RANDOM_PHASES + 1, cycle_count);
      $display("Predicted %0d scrolls and %0d clears, %0d failures",
               scroll_count, clear_count, failures);
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: text_console_writer.f
rtl/core/tcw_pkg.sv
rtl/core/text_console_writer.sv
test/tb_top.sv
